### src/min_heap_timer_queue_core_macros.svh
// ---------------------------------------------------------------------------
// Timer queue assertion macros
// Shared concurrent check forms for the timer queue RTL.
// ---------------------------------------------------------------------------
`ifndef MIN_HEAP_TIMER_QUEUE_CORE_MACROS_SVH
`define MIN_HEAP_TIMER_QUEUE_CORE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define MHTQ_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define MHTQ_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/mhtq_pkg.sv
// ---------------------------------------------------------------------------
// Timer queue package
// Sizes, action and status codes, and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mhtq_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_LIMIT  = 1024;

    localparam int ACT_W     = 3;
    localparam int ID_W      = 10;
    localparam int TMO_W     = 16;
    localparam int WAIT_W    = 17;
    localparam int STAT_W    = 2;
    localparam int EXP_W     = 32;

    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = SLOT_W + 2;
    localparam int HEAP_W    = EXP_W + ID_W;
    localparam int MAP_DEPTH = (ID_LIMIT < (1 << ID_W)) ? ID_LIMIT : (1 << ID_W);
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_ADJUST = 3'd1,
        ACT_FIRE   = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_POP    = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_QUERY  = 3'd6,
        ACT_NOP    = 3'd7
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_EMPTY   = 2'd3
    } stat_t;

    // datapath micro-operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_TICK,
        OP_CLEAR,
        OP_MAP_RD,
        OP_LK_RD,
        OP_SET_ABSENT,
        OP_SET_RANGE,
        OP_SET_FULL,
        OP_EMPTY,
        OP_RESTART,
        OP_NEW,
        OP_FIRE,
        OP_ROOT_RD,
        OP_POP,
        OP_RM_RD,
        OP_RM_END,
        OP_RM_LOAD,
        OP_DN_RDL,
        OP_DN_LQ,
        OP_DN_RQ_R,
        OP_DN_SWAP,
        OP_UP_RD,
        OP_UP_SWAP,
        OP_PLACE,
        OP_DR_TAKE,
        OP_DR_STOP,
        OP_DR_EMPTY,
        OP_OUT_RES,
        OP_OUT_DRN0,
        OP_EM_RD,
        OP_EM_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic drain;      // tick or query
        logic known;      // looked-up id is in the heap
        logic in_range;
        logic full;
        logic empty;
        logic rm_move;    // removed slot is not the last one
        logic has_l;
        logic has_r;
        logic r_lt;       // right child below left child
        logic cur_lt;     // moving entry below best child
        logic moved;
        logic hole_zero;
        logic par_lt;     // parent below moving entry
        logic root_due;
        logic nbuf_zero;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

### src/min_heap_timer_queue_core.sv
// Sequencing: clear, nop and pop of an empty heap go from dispatch straight to the result; add,
//   adjust and fire look up the id and pop reads the root, then the heap is walked by level.
// Tick/query: per due timer a root read, a compare and a removal walk, then one buffer read per
//   result beat.
// Throughput: one input beat in flight; the next is taken once the last result is registered.
// Reset: synchronous aresetn clears count, clock, FSM and output valid; memories are not cleared.
// ---------------------------------------------------------------------------
// Min-heap timer queue
// Timer queue core: binary min-heap on expiry with id lookup, stream ports.
// ---------------------------------------------------------------------------
module min_heap_timer_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // task_id[9:0], timeout_ms[25:10], zero fill
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // fired_id[9:0], wait_ms[26:10], zero fill
    output logic [2:0]  m_tuser,   // fired_valid[0], status[2:1]
    output logic        m_tlast
);
    import mhtq_pkg::*;

    cmd_t                     cmd;
    sts_t                     sts;
    logic [ID_W-1:0]          fired_id;
    logic                     fired_valid;
    logic signed [WAIT_W-1:0] wait_ms;
    logic [STAT_W-1:0]        status;

    mhtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mhtq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_action       (s_tuser[ACT_W-1:0]),
        .in_task_id      (s_tdata[ID_W-1:0]),
        .in_timeout      (s_tdata[ID_W+TMO_W-1:ID_W]),
        .m_tready        (m_tready),
        .out_valid       (m_tvalid),
        .out_fired_id    (fired_id),
        .out_fired_valid (fired_valid),
        .out_wait        (wait_ms),
        .out_status      (status),
        .out_last        (m_tlast)
    );

    // result beat packing
    assign m_tdata = {{(32 - ID_W - WAIT_W){1'b0}}, wait_ms, fired_id};
    assign m_tuser = {status, fired_valid};

endmodule

### src/mhtq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module mhtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/mhtq_ctrl.sv
// ---------------------------------------------------------------------------
// Timer queue controller
// Sequences lookup, heap walks, drain and result output per input beat.
// ---------------------------------------------------------------------------
module mhtq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mhtq_pkg::sts_t sts,
    output mhtq_pkg::cmd_t cmd
);
    import mhtq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_LK_MAP,
        S_LK_HEAP,
        S_LK_CHK,
        S_PP_Q,
        S_RM,
        S_RM_Q,
        S_DN_L,
        S_DN_LQ,
        S_DN_RQ,
        S_DN_CMP,
        S_UP,
        S_UP_Q,
        S_PLACE,
        S_DR_RD,
        S_DR_Q,
        S_DR_FIN,
        S_OUT,
        S_OUT0,
        S_EM_RD,
        S_EM_Q
    } state_t;

    state_t state_reg, state_next;
    state_t cont;

    assign s_tready = (state_reg == S_IDLE);
    assign cont     = sts.drain ? S_DR_RD : S_OUT;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (sts.act) inside
                    ACT_ADD, ACT_ADJUST, ACT_FIRE: begin
                        state_next = S_LK_MAP;
                    end
                    ACT_TICK: begin
                        cmd.op     = OP_TICK;
                        state_next = S_DR_RD;
                    end
                    ACT_POP: begin
                        if (sts.empty) begin
                            cmd.op     = OP_EMPTY;
                            state_next = S_OUT;
                        end else begin
                            cmd.op     = OP_ROOT_RD;
                            state_next = S_PP_Q;
                        end
                    end
                    ACT_CLEAR: begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_OUT;
                    end
                    ACT_QUERY: begin
                        state_next = S_DR_RD;
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_LK_MAP: begin
                cmd.op     = OP_MAP_RD;
                state_next = S_LK_HEAP;
            end
            S_LK_HEAP: begin
                cmd.op     = OP_LK_RD;
                state_next = S_LK_CHK;
            end
            S_LK_CHK: begin
                unique case (sts.act)
                    ACT_ADD: begin
                        if (sts.known) begin
                            cmd.op     = OP_RESTART;
                            state_next = S_DN_L;
                        end else if (!sts.in_range) begin
                            cmd.op     = OP_SET_RANGE;
                            state_next = S_OUT;
                        end else if (sts.full) begin
                            cmd.op     = OP_SET_FULL;
                            state_next = S_OUT;
                        end else begin
                            cmd.op     = OP_NEW;
                            state_next = S_UP;
                        end
                    end
                    ACT_ADJUST: begin
                        if (sts.known) begin
                            cmd.op     = OP_RESTART;
                            state_next = S_DN_L;
                        end else begin
                            cmd.op     = OP_SET_ABSENT;
                            state_next = S_OUT;
                        end
                    end
                    default: begin
                        if (sts.known) begin
                            cmd.op     = OP_FIRE;
                            state_next = S_RM;
                        end else begin
                            cmd.op     = OP_SET_ABSENT;
                            state_next = S_OUT;
                        end
                    end
                endcase
            end
            S_PP_Q: begin
                cmd.op     = OP_POP;
                state_next = S_RM;
            end
            // remove: last entry refills the hole, then sifts
            S_RM: begin
                if (sts.rm_move) begin
                    cmd.op     = OP_RM_RD;
                    state_next = S_RM_Q;
                end else begin
                    cmd.op     = OP_RM_END;
                    state_next = cont;
                end
            end
            S_RM_Q: begin
                cmd.op     = OP_RM_LOAD;
                state_next = S_DN_L;
            end
            // sift down
            S_DN_L: begin
                if (sts.has_l) begin
                    cmd.op     = OP_DN_RDL;
                    state_next = S_DN_LQ;
                end else begin
                    state_next = sts.moved ? S_PLACE : S_UP;
                end
            end
            S_DN_LQ: begin
                cmd.op     = OP_DN_LQ;
                state_next = sts.has_r ? S_DN_RQ : S_DN_CMP;
            end
            S_DN_RQ: begin
                if (sts.r_lt) begin
                    cmd.op = OP_DN_RQ_R;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (sts.cur_lt) begin
                    state_next = sts.moved ? S_PLACE : S_UP;
                end else begin
                    cmd.op     = OP_DN_SWAP;
                    state_next = S_DN_L;
                end
            end
            // sift up
            S_UP: begin
                if (sts.hole_zero) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = OP_UP_RD;
                    state_next = S_UP_Q;
                end
            end
            S_UP_Q: begin
                if (sts.par_lt) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = OP_UP_SWAP;
                    state_next = S_UP;
                end
            end
            S_PLACE: begin
                cmd.op     = OP_PLACE;
                state_next = cont;
            end
            // drain expired timers into the result buffer
            S_DR_RD: begin
                if (sts.empty) begin
                    cmd.op     = OP_DR_EMPTY;
                    state_next = S_DR_FIN;
                end else begin
                    cmd.op     = OP_ROOT_RD;
                    state_next = S_DR_Q;
                end
            end
            S_DR_Q: begin
                if (sts.root_due) begin
                    cmd.op     = OP_DR_TAKE;
                    state_next = S_RM;
                end else begin
                    cmd.op     = OP_DR_STOP;
                    state_next = S_DR_FIN;
                end
            end
            S_DR_FIN: begin
                state_next = sts.nbuf_zero ? S_OUT0 : S_EM_RD;
            end
            // result output
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_OUT_RES;
                    state_next = S_IDLE;
                end
            end
            S_OUT0: begin
                if (sts.out_free) begin
                    cmd.op     = OP_OUT_DRN0;
                    state_next = S_IDLE;
                end
            end
            S_EM_RD: begin
                cmd.op     = OP_EM_RD;
                state_next = S_EM_Q;
            end
            S_EM_Q: begin
                if (sts.out_free) begin
                    cmd.op     = OP_EM_OUT;
                    state_next = sts.emit_last ? S_IDLE : S_EM_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/mhtq_dp.sv
// ---------------------------------------------------------------------------
// Timer queue datapath
// Heap, id map and result buffer memories, walk registers and result register.
// ---------------------------------------------------------------------------
module mhtq_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mhtq_pkg::cmd_t                cmd,
    output mhtq_pkg::sts_t                sts,
    input  logic [mhtq_pkg::ACT_W-1:0]    in_action,
    input  logic [mhtq_pkg::ID_W-1:0]     in_task_id,
    input  logic [mhtq_pkg::TMO_W-1:0]    in_timeout,
    input  logic                          m_tready,
    output logic                          out_valid,
    output logic [mhtq_pkg::ID_W-1:0]     out_fired_id,
    output logic                          out_fired_valid,
    output logic signed [mhtq_pkg::WAIT_W-1:0] out_wait,
    output logic [mhtq_pkg::STAT_W-1:0]   out_status,
    output logic                          out_last
);
    import mhtq_pkg::*;

    // item registers
    act_t               act_reg, act_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [TMO_W-1:0]   tmo_reg, tmo_next;
    // heap state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [EXP_W-1:0]   now_reg, now_next;
    // walk registers
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  hole_reg, hole_next;
    logic               moved_reg, moved_next;
    logic [EXP_W-1:0]   cur_exp_reg, cur_exp_next;
    logic [ID_W-1:0]    cur_own_reg, cur_own_next;
    logic [EXP_W-1:0]   best_exp_reg, best_exp_next;
    logic [ID_W-1:0]    best_own_reg, best_own_next;
    logic [SLOT_W-1:0]  bidx_reg, bidx_next;
    // drain buffer
    logic [CNT_W-1:0]   nbuf_reg, nbuf_next;
    logic [CNT_W-1:0]   eidx_reg, eidx_next;
    logic signed [WAIT_W-1:0] wait_reg, wait_next;
    // single-result fields
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic               res_valid_reg, res_valid_next;
    stat_t              res_status_reg, res_status_next;
    // output register
    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_fv_reg, out_fv_next;
    logic signed [WAIT_W-1:0] out_wait_reg, out_wait_next;
    stat_t              out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    // memory ports
    logic               heap_we, heap_re;
    logic [SLOT_W-1:0]  heap_waddr, heap_raddr;
    logic [HEAP_W-1:0]  heap_wdata, heap_rdata;
    logic               map_we, map_re;
    logic [MAP_AW-1:0]  map_waddr;
    logic [SLOT_W-1:0]  map_wdata, map_rdata;
    logic               buf_we, buf_re;
    logic [ID_W-1:0]    buf_rdata;

    // derived values
    logic [EXP_W-1:0]   hq_exp;
    logic [ID_W-1:0]    hq_own;
    logic [IDX_W-1:0]   lidx, ridx, cnt_x;
    logic [SLOT_W-1:0]  parent;
    logic [EXP_W-1:0]   new_exp, delta;
    logic [WAIT_W-1:0]  sat_wait;
    logic               out_free, out_load;

    assign hq_exp   = heap_rdata[HEAP_W-1:ID_W];
    assign hq_own   = heap_rdata[ID_W-1:0];
    assign lidx     = {1'b0, hole_reg, 1'b1};
    assign ridx     = lidx + IDX_W'(1);
    assign cnt_x    = IDX_W'(count_reg);
    assign parent   = SLOT_W'(hole_reg - SLOT_W'(1)) >> 1;
    assign new_exp  = now_reg + EXP_W'(tmo_reg);
    assign delta    = hq_exp - now_reg;
    assign sat_wait = (delta > EXP_W'(16'hFFFF)) ? WAIT_W'(16'hFFFF) : WAIT_W'(delta);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (cmd.op == OP_OUT_RES) || (cmd.op == OP_OUT_DRN0)
                   || (cmd.op == OP_EM_OUT);

    // status to controller
    always_comb begin
        sts.act       = act_reg;
        sts.drain     = (act_reg == ACT_TICK) || (act_reg == ACT_QUERY);
        sts.in_range  = (32'(id_reg) < 32'(ID_LIMIT));
        sts.known     = sts.in_range && (IDX_W'(slot_reg) < cnt_x) && (hq_own == id_reg);
        sts.full      = (count_reg >= CNT_W'(CAPACITY));
        sts.empty     = (count_reg == '0);
        sts.rm_move   = (IDX_W'(hole_reg) + IDX_W'(1)) < cnt_x;
        sts.has_l     = lidx < cnt_x;
        sts.has_r     = ridx < cnt_x;
        sts.r_lt      = hq_exp < best_exp_reg;
        sts.cur_lt    = cur_exp_reg < best_exp_reg;
        sts.moved     = moved_reg;
        sts.hole_zero = (hole_reg == '0);
        sts.par_lt    = hq_exp < cur_exp_reg;
        sts.root_due  = hq_exp <= now_reg;
        sts.nbuf_zero = (nbuf_reg == '0);
        sts.out_free  = out_free;
        sts.emit_last = (eidx_reg + CNT_W'(1)) == nbuf_reg;
    end

    // micro-operation execution
    always_comb begin
        act_next        = act_reg;
        id_next         = id_reg;
        tmo_next        = tmo_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        slot_next       = slot_reg;
        hole_next       = hole_reg;
        moved_next      = moved_reg;
        cur_exp_next    = cur_exp_reg;
        cur_own_next    = cur_own_reg;
        best_exp_next   = best_exp_reg;
        best_own_next   = best_own_reg;
        bidx_next       = bidx_reg;
        nbuf_next       = nbuf_reg;
        eidx_next       = eidx_reg;
        wait_next       = wait_reg;
        res_id_next     = res_id_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        out_id_next     = out_id_reg;
        out_fv_next     = out_fv_reg;
        out_wait_next   = out_wait_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        heap_we         = 1'b0;
        heap_waddr      = hole_reg;
        heap_wdata      = {cur_exp_reg, cur_own_reg};
        heap_re         = 1'b0;
        heap_raddr      = '0;
        map_we          = 1'b0;
        map_waddr       = cur_own_reg[MAP_AW-1:0];
        map_wdata       = hole_reg;
        map_re          = 1'b0;
        buf_we          = 1'b0;
        buf_re          = 1'b0;
        case (cmd.op)
            OP_ACCEPT: begin
                act_next        = act_t'(in_action);
                id_next         = in_task_id;
                tmo_next        = in_timeout;
                nbuf_next       = '0;
                eidx_next       = '0;
                wait_next       = '0;
                res_id_next     = '0;
                res_valid_next  = 1'b0;
                res_status_next = STAT_OK;
            end
            OP_TICK:  now_next   = now_reg + EXP_W'(1);
            OP_CLEAR: count_next = '0;
            OP_MAP_RD: map_re    = 1'b1;
            OP_LK_RD: begin
                heap_re    = 1'b1;
                heap_raddr = map_rdata;
                slot_next  = map_rdata;
            end
            OP_SET_ABSENT: res_status_next = sts.empty ? STAT_EMPTY : STAT_UNKNOWN;
            OP_SET_RANGE:  res_status_next = STAT_UNKNOWN;
            OP_SET_FULL:   res_status_next = STAT_FULL;
            OP_EMPTY:      res_status_next = STAT_EMPTY;
            OP_RESTART: begin
                cur_exp_next = new_exp;
                cur_own_next = id_reg;
                hole_next    = slot_reg;
                moved_next   = 1'b0;
            end
            OP_NEW: begin
                cur_exp_next = new_exp;
                cur_own_next = id_reg;
                hole_next    = SLOT_W'(count_reg);
                count_next   = count_reg + CNT_W'(1);
            end
            OP_FIRE: begin
                res_id_next    = id_reg;
                res_valid_next = 1'b1;
                hole_next      = slot_reg;
            end
            OP_ROOT_RD: heap_re = 1'b1;
            OP_POP: begin
                res_id_next = hq_own;
                hole_next   = '0;
            end
            OP_RM_RD: begin
                heap_re    = 1'b1;
                heap_raddr = SLOT_W'(count_reg - CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
            end
            OP_RM_END: count_next = count_reg - CNT_W'(1);
            OP_RM_LOAD: begin
                cur_exp_next = hq_exp;
                cur_own_next = hq_own;
                moved_next   = 1'b0;
            end
            OP_DN_RDL: begin
                heap_re    = 1'b1;
                heap_raddr = lidx[SLOT_W-1:0];
            end
            OP_DN_LQ: begin
                best_exp_next = hq_exp;
                best_own_next = hq_own;
                bidx_next     = lidx[SLOT_W-1:0];
                heap_re       = 1'b1;
                heap_raddr    = ridx[SLOT_W-1:0];
            end
            OP_DN_RQ_R: begin
                best_exp_next = hq_exp;
                best_own_next = hq_own;
                bidx_next     = ridx[SLOT_W-1:0];
            end
            // child moves up into the hole
            OP_DN_SWAP: begin
                heap_we    = 1'b1;
                heap_wdata = {best_exp_reg, best_own_reg};
                map_we     = 1'b1;
                map_waddr  = best_own_reg[MAP_AW-1:0];
                hole_next  = bidx_reg;
                moved_next = 1'b1;
            end
            OP_UP_RD: begin
                heap_re    = 1'b1;
                heap_raddr = parent;
            end
            // parent moves down into the hole
            OP_UP_SWAP: begin
                heap_we    = 1'b1;
                heap_wdata = heap_rdata;
                map_we     = 1'b1;
                map_waddr  = hq_own[MAP_AW-1:0];
                hole_next  = parent;
            end
            OP_PLACE: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
            end
            OP_DR_TAKE: begin
                buf_we    = 1'b1;
                nbuf_next = nbuf_reg + CNT_W'(1);
                hole_next = '0;
            end
            OP_DR_STOP:  wait_next = (act_reg == ACT_QUERY) ? $signed(sat_wait) : '0;
            OP_DR_EMPTY: wait_next = (act_reg == ACT_QUERY) ? '1 : '0;
            OP_OUT_RES: begin
                out_id_next     = res_id_reg;
                out_fv_next     = res_valid_reg;
                out_wait_next   = wait_reg;
                out_status_next = res_status_reg;
                out_last_next   = 1'b1;
            end
            OP_OUT_DRN0: begin
                out_id_next     = '0;
                out_fv_next     = 1'b0;
                out_wait_next   = wait_reg;
                out_status_next = sts.empty ? STAT_EMPTY : STAT_OK;
                out_last_next   = 1'b1;
            end
            OP_EM_RD: buf_re = 1'b1;
            OP_EM_OUT: begin
                out_id_next     = buf_rdata;
                out_fv_next     = 1'b1;
                out_wait_next   = wait_reg;
                out_status_next = wait_reg[WAIT_W-1] ? STAT_EMPTY : STAT_OK;
                out_last_next   = sts.emit_last;
                eidx_next       = eidx_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
            nbuf_reg      <= '0;
            eidx_reg      <= '0;
            moved_reg     <= 1'b0;
            act_reg       <= ACT_NOP;
        end else begin
            count_reg     <= count_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
            nbuf_reg      <= nbuf_next;
            eidx_reg      <= eidx_next;
            moved_reg     <= moved_next;
            act_reg       <= act_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        tmo_reg        <= tmo_next;
        slot_reg       <= slot_next;
        hole_reg       <= hole_next;
        cur_exp_reg    <= cur_exp_next;
        cur_own_reg    <= cur_own_next;
        best_exp_reg   <= best_exp_next;
        best_own_reg   <= best_own_next;
        bidx_reg       <= bidx_next;
        wait_reg       <= wait_next;
        res_id_reg     <= res_id_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_fv_reg     <= out_fv_next;
        out_wait_reg   <= out_wait_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // heap entries: expiry and owner id
    mhtq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .re    (heap_re),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    // id to heap slot map; presence is slot < count with matching owner
    mhtq_ram #(.WIDTH(SLOT_W), .DEPTH(MAP_DEPTH)) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (id_reg[MAP_AW-1:0]),
        .rdata (map_rdata)
    );

    // expired ids held until the drain answer is known
    mhtq_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (nbuf_reg[SLOT_W-1:0]),
        .wdata (hq_own),
        .re    (buf_re),
        .raddr (eidx_reg[SLOT_W-1:0]),
        .rdata (buf_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign out_fired_id    = out_id_reg;
    assign out_fired_valid = out_fv_reg;
    assign out_wait        = out_wait_reg;
    assign out_status      = out_status_reg;
    assign out_last        = out_last_reg;

`include "min_heap_timer_queue_core_macros.svh"

    `MHTQ_ALWAYS(a_count_cap, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "heap count over capacity")
    `MHTQ_IMPLY(a_load_free, aclk, aresetn, out_load, out_free, "result overwrites a pending beat")
    `MHTQ_IMPLY(a_take_room, aclk, aresetn, cmd.op == OP_DR_TAKE, (count_reg != '0) && (nbuf_reg < CNT_W'(CAPACITY)), "drain take without entry or buffer room")
    `MHTQ_ALWAYS(a_emit_bound, aclk, aresetn, eidx_reg <= nbuf_reg, "emit index past buffered results")

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// Timer queue core testbench
// Drives timer actions on the input stream and checks every result beat
// against a behavioral min-heap timer predictor, with and without random stalls.
// ---------------------------------------------------------------------------
module tb_top;
    import mhtq_pkg::*;

    typedef struct {
        logic [9:0]  fired_id;
        logic        fired_valid;
        logic [16:0] wait_ms;
        logic [1:0]  status;
        logic        last;
    } timer_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    min_heap_timer_queue_core uut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [31:0] pexp [CAPACITY];
    logic [9:0]  powner [CAPACITY];
    int          pslot [ID_LIMIT];
    bit          ppresent [ID_LIMIT];
    int          pcount;
    logic [31:0] pnow;

    timer_res_t  expected_q [$];
    int          fail_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    function automatic void swap_entries(int a, int b);
        logic [31:0] e;
        logic [9:0]  o;
        e = pexp[a]; o = powner[a];
        pexp[a] = pexp[b]; powner[a] = powner[b];
        pexp[b] = e; powner[b] = o;
        pslot[powner[a]] = a;
        pslot[powner[b]] = b;
    endfunction

    function automatic void heap_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (pexp[p] < pexp[i]) break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    function automatic bit heap_down(int start, int n);
        int i;
        int c;
        i = start;
        c = 2 * i + 1;
        while (c < n) begin
            if (c + 1 < n && pexp[c+1] < pexp[c]) c++;
            if (pexp[i] < pexp[c]) break;
            swap_entries(i, c);
            i = c;
            c = 2 * i + 1;
        end
        return i > start;
    endfunction

    function automatic void heap_remove(int i);
        int n;
        n = pcount - 1;
        if (i < n) begin
            swap_entries(i, n);
            if (!heap_down(i, n)) heap_up(i);
        end
        ppresent[powner[n]] = 0;
        pcount = n;
    endfunction

    function automatic void push_res(logic [9:0] id, logic v, logic [16:0] w, logic [1:0] st);
        timer_res_t r;
        r.fired_id = id; r.fired_valid = v; r.wait_ms = w; r.status = st; r.last = 0;
        expected_q.insert(expected_q.size(), r);
    endfunction

    // expire due timers; returns number of results queued
    function automatic int drain_due();
        int k;
        k = 0;
        while (pcount > 0 && pexp[0] <= pnow && k < CAPACITY) begin
            push_res(powner[0], 1, 0, STAT_OK);
            k++;
            heap_remove(0);
        end
        if (k == 0) begin
            push_res(0, 0, 0, pcount == 0 ? STAT_EMPTY : STAT_OK);
            k = 1;
        end
        return k;
    endfunction

    function automatic void predict_timer(act_t act, logic [9:0] id, logic [15:0] tmo);
        bit          known;
        logic [1:0]  absent;
        int          k;
        int          s;
        int          base;
        logic [31:0] d;
        logic [16:0] w;
        known = ppresent[id];
        absent = pcount == 0 ? STAT_EMPTY : STAT_UNKNOWN;
        base = expected_q.size();
        case (act)
            ACT_ADD, ACT_ADJUST: begin
                if (known) begin
                    s = pslot[id];
                    pexp[s] = pnow + tmo;
                    if (!heap_down(s, pcount)) heap_up(s);
                    push_res(0, 0, 0, STAT_OK);
                end else if (act == ACT_ADJUST) begin
                    push_res(0, 0, 0, absent);
                end else if (pcount >= CAPACITY) begin
                    push_res(0, 0, 0, STAT_FULL);
                end else begin
                    s = pcount;
                    pexp[s] = pnow + tmo; powner[s] = id;
                    pslot[id] = s; ppresent[id] = 1;
                    pcount++;
                    heap_up(s);
                    push_res(0, 0, 0, STAT_OK);
                end
            end
            ACT_FIRE: begin
                if (known) begin
                    push_res(id, 1, 0, STAT_OK);
                    heap_remove(pslot[id]);
                end else push_res(0, 0, 0, absent);
            end
            ACT_TICK: begin
                pnow++;
                void'(drain_due());
            end
            ACT_POP: begin
                if (pcount == 0) push_res(0, 0, 0, STAT_EMPTY);
                else begin
                    push_res(powner[0], 0, 0, STAT_OK);
                    heap_remove(0);
                end
            end
            ACT_CLEAR: begin
                foreach (ppresent[i]) ppresent[i] = 0;
                pcount = 0;
                push_res(0, 0, 0, STAT_OK);
            end
            ACT_QUERY: begin
                k = drain_due();
                w = 17'h1FFFF;
                if (pcount > 0) begin
                    d = (pexp[0] <= pnow) ? 0 : pexp[0] - pnow;
                    w = d > 65535 ? 17'd65535 : d[16:0];
                end
                for (int j = base; j < base + k; j++) begin
                    expected_q[j].wait_ms = w;
                    if (pcount == 0) expected_q[j].status = STAT_EMPTY;
                end
            end
            default: push_res(0, 0, 0, STAT_OK);
        endcase
        expected_q[expected_q.size()-1].last = 1;
    endfunction

    // send one beat, predicting on acceptance
    task automatic send_action(act_t act, logic [9:0] id, logic [15:0] tmo);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge aclk);
        s_tvalid <= 1; s_tuser <= act; s_tdata <= {6'd0, tmo, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_timer(act, id, tmo);
        s_tvalid <= 0;
        // core drops ready while it works on the accepted beat
        @(posedge aclk);
    endtask

    task automatic wait_quiet();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    timer_res_t e;
                    e = expected_q.pop_front();
                    if (m_tdata[9:0] !== e.fired_id) begin
                        $error("fired_id exp %0d got %0d", e.fired_id, m_tdata[9:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.fired_valid) begin
                        $error("fired_valid exp %0d got %0d", e.fired_valid, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[26:10] !== e.wait_ms) begin
                        $error("wait_ms exp %h got %h", e.wait_ms, m_tdata[26:10]);
                        fail_count++;
                    end
                    if (m_tuser[2:1] !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_tuser[2:1]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
        end
    end

    // corner cases on an empty and then small heap
    task automatic test_directed();
        send_action(ACT_POP, 0, 0);
        send_action(ACT_FIRE, 5, 0);
        send_action(ACT_ADJUST, 5, 0);
        send_action(ACT_QUERY, 0, 0);
        send_action(ACT_TICK, 0, 0);
        send_action(ACT_ADD, 10'h3FF, 16'hFFFF);
        send_action(ACT_ADD, 0, 0);
        send_action(ACT_ADD, 7, 3);
        send_action(ACT_ADD, 8, 3);
        send_action(ACT_QUERY, 0, 0);
        send_action(ACT_ADJUST, 8, 1);
        send_action(ACT_FIRE, 9, 0);
        send_action(ACT_ADD, 7, 2);
        send_action(ACT_TICK, 0, 0);
        send_action(ACT_QUERY, 0, 0);
        send_action(ACT_FIRE, 7, 0);
        send_action(ACT_NOP, 10'h155, 16'hAAAA);
        send_action(ACT_POP, 0, 0);
        send_action(ACT_CLEAR, 0, 0);
        send_action(ACT_QUERY, 0, 0);
    endtask

    // fill to capacity, then overflow and drain by ticks
    task automatic test_full_heap();
        for (int i = 0; i < CAPACITY; i++)
            send_action(ACT_ADD, 10'(i * 13 + 1), 16'($urandom_range(2, 6)));
        send_action(ACT_ADD, 10'd1000, 0);
        send_action(ACT_ADD, 10'd14, 9);
        wait_quiet();
        repeat (8) send_action(ACT_TICK, 0, 0);
        send_action(ACT_QUERY, 0, 0);
        send_action(ACT_CLEAR, 0, 0);
    endtask

    // random mix over a small id pool so hits are frequent
    task automatic test_random(int n);
        act_t        a;
        logic [9:0]  id;
        logic [15:0] t;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            a = r < 35 ? ACT_ADD : r < 45 ? ACT_ADJUST : r < 55 ? ACT_FIRE :
                r < 80 ? ACT_TICK : r < 88 ? ACT_POP : r < 90 ? ACT_CLEAR :
                r < 98 ? ACT_QUERY : ACT_NOP;
            id = $urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(40));
            t = $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(12));
            send_action(a, id, t);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        pcount = 0; pnow = 0;
        foreach (ppresent[i]) ppresent[i] = 0;
        @(posedge aclk);
        send_idle = 6; recv_idle = 65;
        test_directed();
        test_full_heap();
        test_random(70);
        // hold off until all results are in
        wait_quiet();
        send_idle = 65; recv_idle = 6;
        test_random(70);
        send_idle = 0; recv_idle = 0;
        test_random(70);
        wait_quiet();
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/mhtq_pkg.sv
src/mhtq_ram.sv
src/mhtq_ctrl.sv
src/mhtq_dp.sv
src/min_heap_timer_queue_core.sv
tb/tb_top.sv
